// ===== design/erw_pkg.sv =====
// Package for the body-to-world rotation block: CORDIC constants and types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package erw_pkg;
  localparam int AtanEntries = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam int TrigQ = 14;

  function automatic logic signed [33:0] atan_turn32(input int unsigned i);
    logic signed [33:0] t;
    begin
      case (i)
        0: t = 34'sd536870912;
        1: t = 34'sd316933406;
        2: t = 34'sd167458907;
        3: t = 34'sd85004756;
        4: t = 34'sd42667331;
        5: t = 34'sd21354465;
        6: t = 34'sd10679838;
        7: t = 34'sd5340245;
        8: t = 34'sd2670163;
        9: t = 34'sd1335087;
        10: t = 34'sd667544;
        11: t = 34'sd333772;
        12: t = 34'sd166886;
        13: t = 34'sd83443;
        14: t = 34'sd41722;
        15: t = 34'sd20861;
        16: t = 34'sd10430;
        17: t = 34'sd5215;
        18: t = 34'sd2608;
        19: t = 34'sd1304;
        20: t = 34'sd652;
        21: t = 34'sd326;
        22: t = 34'sd163;
        23: t = 34'sd81;
        default: t = 34'sd0;
      endcase
      return t;
    end
  endfunction

  // sin/cos pair of one angle, Q14 (range [-16384, 16384])
  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] s;
  } trig_t;
endpackage
`default_nettype wire

// ===== design/erw_cordic.sv =====
// Pipelined rotation-mode CORDIC: binary angle in, Q14 cosine and sine out.
// Depends on erw_pkg. One stage per iteration; advances when en_i is high.
`timescale 1ns / 1ps
`default_nettype none
module erw_cordic #(
  parameter int ANGLE_WIDTH = 16,
  parameter int STAGES      = 16
) (
  input  wire                   clk_i,
  input  wire                   en_i,
  input  wire [ANGLE_WIDTH-1:0] angle_i,
  output erw_pkg::trig_t        trig_o
);
  localparam int N = (STAGES < erw_pkg::AtanEntries) ? STAGES : erw_pkg::AtanEntries;

  logic signed [33:0] x_q [N+1];
  logic signed [33:0] y_q [N+1];
  logic signed [33:0] z_q [N+1];
  logic [1:0]         quad_q [N+1];

  logic [31:0] a_w;
  logic [31:0] r_w;
  logic [1:0]  quad_w;
  assign a_w    = {angle_i, {(32-ANGLE_WIDTH){1'b0}}};
  assign quad_w = 2'((a_w + 32'h2000_0000) >> 30);
  assign r_w    = a_w - {quad_w, 30'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= erw_pkg::CordicGain;
      y_q[0]    <= '0;
      z_q[0]    <= 34'(signed'(r_w));
      quad_q[0] <= quad_w;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - erw_pkg::atan_turn32(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + erw_pkg::atan_turn32(i);
        end
        quad_q[i+1] <= quad_q[i];
      end
    end
  end

  logic signed [33:0] cr_w, sr_w;
  logic signed [15:0] c_w, s_w;
  assign cr_w = (x_q[N] + 34'sd32768) >>> 16;
  assign sr_w = (y_q[N] + 34'sd32768) >>> 16;
  assign c_w  = 16'(cr_w);
  assign s_w  = 16'(sr_w);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[N])
        2'd0: begin trig_o.c <= c_w;  trig_o.s <= s_w;  end
        2'd1: begin trig_o.c <= -s_w; trig_o.s <= c_w;  end
        2'd2: begin trig_o.c <= -c_w; trig_o.s <= -s_w; end
        default: begin trig_o.c <= s_w; trig_o.s <= -c_w; end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/erw_matrix.sv =====
// Rotation matrix and vector product stages, Q14 entries, saturated output.
// Depends on erw_pkg. Stages A-D and the output register advance when en_i is high.
`timescale 1ns / 1ps
`default_nettype none
module erw_matrix #(
  parameter int VEC_WIDTH = 16
) (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  erw_pkg::trig_t             roll_i,
  input  erw_pkg::trig_t             pitch_i,
  input  erw_pkg::trig_t             yaw_i,
  input  wire signed [VEC_WIDTH-1:0] vx_i,
  input  wire signed [VEC_WIDTH-1:0] vy_i,
  input  wire signed [VEC_WIDTH-1:0] vz_i,
  output logic signed [VEC_WIDTH-1:0] wx_o,
  output logic signed [VEC_WIDTH-1:0] wy_o,
  output logic signed [VEC_WIDTH-1:0] wz_o
);
  localparam int PW = VEC_WIDTH + 20;

  // stage A: pairwise products (Q28)
  logic signed [31:0] c3c2_q, s3c2_q, c3s2_q, s3s2_q, s3c1_q, s3s1_q, c3c1_q, c3s1_q;
  logic signed [31:0] c2s1_q, c2c1_q;
  logic signed [15:0] s1_q, c1_q, s2_q;
  logic signed [VEC_WIDTH-1:0] va_q [3];
  // stage B: matrix entries Q42 rounded to Q14
  logic signed [17:0] m_q [9];
  logic signed [VEC_WIDTH-1:0] vb_q [3];
  // stage C: entry times component
  logic signed [PW-1:0] p_q [9];
  // stage D: row sums
  logic signed [PW+1:0] sum_q [3];

  function automatic logic signed [17:0] rnd28(input logic signed [47:0] v);
    logic signed [47:0] t;
    begin
      t = (v + 48'sd134217728) >>> 28;
      return 18'(t);
    end
  endfunction

  function automatic logic signed [VEC_WIDTH-1:0] sat(input logic signed [PW+1:0] s);
    logic signed [PW+1:0] t;
    logic signed [PW+1:0] hi, lo;
    begin
      t  = (s + (PW+2)'(8192)) >>> 14;
      hi = (PW+2)'((64'sd1 <<< (VEC_WIDTH-1)) - 1);
      lo = -hi - 1;
      if (t > hi) t = hi;
      if (t < lo) t = lo;
      return VEC_WIDTH'(t);
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c3c2_q <= yaw_i.c * pitch_i.c;
      s3c2_q <= yaw_i.s * pitch_i.c;
      c3s2_q <= yaw_i.c * pitch_i.s;
      s3s2_q <= yaw_i.s * pitch_i.s;
      s3c1_q <= yaw_i.s * roll_i.c;
      s3s1_q <= yaw_i.s * roll_i.s;
      c3c1_q <= yaw_i.c * roll_i.c;
      c3s1_q <= yaw_i.c * roll_i.s;
      c2s1_q <= pitch_i.c * roll_i.s;
      c2c1_q <= pitch_i.c * roll_i.c;
      s1_q   <= roll_i.s;
      c1_q   <= roll_i.c;
      s2_q   <= pitch_i.s;
      va_q[0] <= vx_i;
      va_q[1] <= vy_i;
      va_q[2] <= vz_i;

      m_q[0] <= rnd28(48'(c3c2_q) <<< 14);
      m_q[1] <= rnd28(48'(c3s2_q) * 48'(s1_q) - (48'(s3c1_q) <<< 14));
      m_q[2] <= rnd28(48'(c3s2_q) * 48'(c1_q) + (48'(s3s1_q) <<< 14));
      m_q[3] <= rnd28(48'(s3c2_q) <<< 14);
      m_q[4] <= rnd28(48'(s3s2_q) * 48'(s1_q) + (48'(c3c1_q) <<< 14));
      m_q[5] <= rnd28(48'(s3s2_q) * 48'(c1_q) - (48'(c3s1_q) <<< 14));
      m_q[6] <= rnd28(-(48'(s2_q) <<< 28));
      m_q[7] <= rnd28(48'(c2s1_q) <<< 14);
      m_q[8] <= rnd28(48'(c2c1_q) <<< 14);
      vb_q <= va_q;

      for (int k = 0; k < 9; k++) begin
        p_q[k] <= PW'(m_q[k]) * PW'(vb_q[k % 3]);
      end

      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= (PW+2)'(p_q[3*r]) + (PW+2)'(p_q[3*r+1]) + (PW+2)'(p_q[3*r+2]);
      end

      wx_o <= sat(sum_q[0]);
      wy_o <= sat(sum_q[1]);
      wz_o <= sat(sum_q[2]);
    end
  end
endmodule
`default_nettype wire

// ===== design/euler_rotate_vector_to_world_unit.sv =====
// Top level of the ZYX Euler body-to-world vector rotation pipeline.
// Depends on erw_pkg, erw_cordic and erw_matrix.
//
// Use: a request carries a body-frame vector (acc_*_i, signed Q7.8) and
// roll/pitch/yaw as binary angles (full turn = 2^ANGLE_WIDTH). It is taken
// when in_valid_i is high and in_stall_o is low. The result, the world-frame
// vector saturated to VEC_WIDTH bits, leaves on out_valid_o / world_*_o and
// is taken when out_stall_i is low.
// Stages: CORDIC prep, one per iteration, quadrant map, then five matrix/
// product/sum/round stages. Throughput: one request per cycle unless the
// output stalls; each of the three CORDICs is fully unrolled in stages.
// Stall: the whole pipe freezes as one while the output holds a result and
// out_stall_i is high; in_stall_o is then high too. Otherwise every stage
// advances each cycle, so nothing is lost or repeated; bubbles already in
// the pipe are not squeezed out.
// Reset: clears only the valid bits; data registers hold arbitrary values.
`timescale 1ns / 1ps
`default_nettype none
module euler_rotate_vector_to_world_unit #(
  parameter int VEC_WIDTH     = 16,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire signed [VEC_WIDTH-1:0]  acc_x_i,
  input  wire signed [VEC_WIDTH-1:0]  acc_y_i,
  input  wire signed [VEC_WIDTH-1:0]  acc_z_i,
  input  wire [ANGLE_WIDTH-1:0]       roll_angle_i,
  input  wire [ANGLE_WIDTH-1:0]       pitch_angle_i,
  input  wire [ANGLE_WIDTH-1:0]       yaw_angle_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic signed [VEC_WIDTH-1:0] world_x_o,
  output logic signed [VEC_WIDTH-1:0] world_y_o,
  output logic signed [VEC_WIDTH-1:0] world_z_o
);
  localparam int NC  = (CORDIC_STAGES < erw_pkg::AtanEntries) ?
                       CORDIC_STAGES : erw_pkg::AtanEntries;
  localparam int CL  = NC + 2;       // CORDIC latency
  localparam int LAT = CL + 5;       // total latency

  logic en_w;
  logic [LAT-1:0] vld_q;

  // global enable: move unless a finished result is held
  assign en_w        = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en_w;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_w) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  erw_pkg::trig_t roll_w, pitch_w, yaw_w;

  erw_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_roll (
    .clk_i(clk_i), .en_i(en_w), .angle_i(roll_angle_i), .trig_o(roll_w));
  erw_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_pitch (
    .clk_i(clk_i), .en_i(en_w), .angle_i(pitch_angle_i), .trig_o(pitch_w));
  erw_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_yaw (
    .clk_i(clk_i), .en_i(en_w), .angle_i(yaw_angle_i), .trig_o(yaw_w));

  // vector delay line alongside the CORDICs
  logic signed [VEC_WIDTH-1:0] vx_q [CL];
  logic signed [VEC_WIDTH-1:0] vy_q [CL];
  logic signed [VEC_WIDTH-1:0] vz_q [CL];

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      vx_q[0] <= acc_x_i;
      vy_q[0] <= acc_y_i;
      vz_q[0] <= acc_z_i;
      for (int k = 1; k < CL; k++) begin
        vx_q[k] <= vx_q[k-1];
        vy_q[k] <= vy_q[k-1];
        vz_q[k] <= vz_q[k-1];
      end
    end
  end

  erw_matrix #(.VEC_WIDTH(VEC_WIDTH)) u_matrix (
    .clk_i(clk_i), .en_i(en_w),
    .roll_i(roll_w), .pitch_i(pitch_w), .yaw_i(yaw_w),
    .vx_i(vx_q[CL-1]), .vy_i(vy_q[CL-1]), .vz_i(vz_q[CL-1]),
    .wx_o(world_x_o), .wy_o(world_y_o), .wz_o(world_z_o));

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(world_x_o)))
    else $error("held result changed");
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output held");
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("stall with empty output");
endmodule
`default_nettype wire
